// ===== rtl/core/sep_pkg.sv =====
// ============================================================================
// sep_pkg
// shared types, constants and tag lookups of the event-stream parser
// ============================================================================
package sep_pkg;

    // store sizes
    localparam int DATA_DEPTH = 256;
    localparam int NAME_DEPTH = 64;
    localparam int DATA_AW    = $clog2(DATA_DEPTH);
    localparam int NAME_AW    = $clog2(NAME_DEPTH);
    localparam int DATA_CW    = $clog2(DATA_DEPTH + 1);
    localparam int NAME_CW    = $clog2(NAME_DEPTH + 1);

    // field widths of a word
    localparam int MODE_W     = 2;
    localparam int BYTE_W     = 8;
    localparam int INDEX_W    = 8;
    localparam int DATA_LEN_W = 9;
    localparam int NAME_LEN_W = 7;

    // line characters
    localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;

    // line position tracking, saturates at LINE_POS_MAX
    localparam logic [2:0] LINE_POS_MAX  = 3'd7;
    localparam logic [2:0] DATA_TAG_LEN  = 3'd6;
    localparam logic [2:0] NAME_TAG_LEN  = 3'd7;
    localparam logic [2:0] DATA_TAG_LAST = 3'd5;
    localparam logic [2:0] NAME_TAG_LAST = 3'd6;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH      = 2'd0,
        MODE_READ_DATA = 2'd1,
        MODE_READ_NAME = 2'd2
    } mode_t;

    typedef struct packed {
        logic                  done;
        logic [DATA_LEN_W-1:0] data_length;
        logic                  name_present;
        logic [NAME_LEN_W-1:0] name_length;
        logic                  truncated;
    } evt_result_t;

    typedef struct packed {
        logic               en;
        logic [DATA_AW-1:0] addr;
        logic [BYTE_W-1:0]  data;
    } data_wr_t;

    typedef struct packed {
        logic               en;
        logic [NAME_AW-1:0] addr;
        logic [BYTE_W-1:0]  data;
    } name_wr_t;

    // "data: "
    function automatic logic [BYTE_W-1:0] data_tag_char(input logic [2:0] pos);
        logic [BYTE_W-1:0] c;
        case (pos)
            3'd0:    c = 8'h64;
            3'd1:    c = 8'h61;
            3'd2:    c = 8'h74;
            3'd3:    c = 8'h61;
            3'd4:    c = 8'h3A;
            3'd5:    c = 8'h20;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "event: "
    function automatic logic [BYTE_W-1:0] name_tag_char(input logic [2:0] pos);
        logic [BYTE_W-1:0] c;
        case (pos)
            3'd0:    c = 8'h65;
            3'd1:    c = 8'h76;
            3'd2:    c = 8'h65;
            3'd3:    c = 8'h6E;
            3'd4:    c = 8'h74;
            3'd5:    c = 8'h3A;
            3'd6:    c = 8'h20;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/core/sse_event_stream_parser_top.sv =====
// ============================================================================
// sse_event_stream_parser_top
// event-stream parser: one stream byte or one store read per word
// ============================================================================
// usage
//   input channel s_*: each word is either a stream byte to parse (mode push),
//   a read of the data store or a read of the name store at s_read_index
//   output channel m_*: exactly one word per input word, in order; event_done
//   marks the word whose line end closed an event with non-empty data, and
//   read_value carries the fetched byte for read words
//   path: an accepted word is held in the input register, then parser and
//   store read move it into the output register
//   throughput: one word per cycle while m_ready stays high, set by the parser
//   updating its state per word and the one read port of each store
//   reset (aresetn low, synchronous): parser state and both valid flags clear;
//   store contents stay undefined until written, no clearing pass is run
//   stall: when m_ready is low the output word holds, the input register
//   fills behind it and s_ready drops once both stages are occupied
// ============================================================================
module sse_event_stream_parser_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [sep_pkg::MODE_W-1:0]     s_mode,
    input  logic [sep_pkg::BYTE_W-1:0]     s_stream_byte,
    input  logic [sep_pkg::INDEX_W-1:0]    s_read_index,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_event_done,
    output logic [sep_pkg::DATA_LEN_W-1:0] m_data_length,
    output logic                          m_name_present,
    output logic [sep_pkg::NAME_LEN_W-1:0] m_name_length,
    output logic                          m_truncated,
    output logic [sep_pkg::BYTE_W-1:0]     m_read_value
);
    import sep_pkg::*;

    // input stage
    logic                v1_reg;
    logic [MODE_W-1:0]   mode1_reg;
    logic [BYTE_W-1:0]   byte1_reg;
    logic [INDEX_W-1:0]  idx1_reg;

    // output stage
    logic                m_valid_reg;
    evt_result_t         result_reg;
    logic                sel_data_reg;
    logic                sel_name_reg;

    logic                adv2;      // output stage can take a word
    logic                fire1;     // input stage moves to output stage
    logic                push_en;
    logic                rd_data_hit;
    logic                rd_name_hit;
    evt_result_t         result;
    data_wr_t            data_wr;
    name_wr_t            name_wr;
    logic [BYTE_W-1:0]   data_rd;
    logic [BYTE_W-1:0]   name_rd;

    assign adv2    = !m_valid_reg || m_ready;
    assign fire1   = v1_reg && adv2;
    assign s_ready = !v1_reg || adv2;

    // decode of the word in the input stage
    always_comb begin
        push_en     = 1'b0;
        rd_data_hit = 1'b0;
        rd_name_hit = 1'b0;
        case (mode1_reg)
            MODE_PUSH:      push_en     = fire1;
            MODE_READ_DATA: rd_data_hit = (32'(idx1_reg) < DATA_DEPTH);
            MODE_READ_NAME: rd_name_hit = (32'(idx1_reg) < NAME_DEPTH);
            default: ;  // unused mode: all fields zero
        endcase
    end

    sep_line_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push_en     (push_en),
        .stream_byte (byte1_reg),
        .result      (result),
        .data_wr     (data_wr),
        .name_wr     (name_wr)
    );

    // read data lands in the ram output register together with the output stage
    sep_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DATA_DEPTH)
    ) u_data_ram (
        .aclk    (aclk),
        .wr_en   (data_wr.en),
        .wr_addr (data_wr.addr),
        .wr_data (data_wr.data),
        .rd_en   (fire1),
        .rd_addr (DATA_AW'(idx1_reg)),
        .rd_data (data_rd)
    );

    sep_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (NAME_DEPTH)
    ) u_name_ram (
        .aclk    (aclk),
        .wr_en   (name_wr.en),
        .wr_addr (name_wr.addr),
        .wr_data (name_wr.data),
        .rd_en   (fire1),
        .rd_addr (NAME_AW'(idx1_reg)),
        .rd_data (name_rd)
    );

    // valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                v1_reg <= s_valid;
            end
            if (adv2) begin
                m_valid_reg <= v1_reg;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            mode1_reg <= s_mode;
            byte1_reg <= s_stream_byte;
            idx1_reg  <= s_read_index;
        end
        if (fire1) begin
            result_reg   <= result;
            sel_data_reg <= rd_data_hit;
            sel_name_reg <= rd_name_hit;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_event_done   = result_reg.done;
    assign m_data_length  = result_reg.data_length;
    assign m_name_present = result_reg.name_present;
    assign m_name_length  = result_reg.name_length;
    assign m_truncated    = result_reg.truncated;
    assign m_read_value   = sel_data_reg ? data_rd :
                            sel_name_reg ? name_rd : '0;

endmodule

// ===== rtl/core/sep_ram.sv =====
// ============================================================================
// sep_ram
// generic single-write, single-read ram with registered read
// ============================================================================
module sep_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/sep_line_parser.sv =====
// ============================================================================
// sep_line_parser
// line splitting, tag matching and event bookkeeping, one byte per cycle while push_en is high
// ============================================================================
module sep_line_parser (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      push_en,
    input  logic [sep_pkg::BYTE_W-1:0] stream_byte,
    output sep_pkg::evt_result_t      result,
    output sep_pkg::data_wr_t         data_wr,
    output sep_pkg::name_wr_t         name_wr
);
    import sep_pkg::*;

    logic [DATA_CW-1:0] data_count_reg, data_count_next;
    logic [NAME_CW-1:0] name_count_reg, name_count_next;
    logic               name_seen_reg, name_seen_next;
    logic               line_end_reg, line_end_next;
    logic               after_cr_reg, after_cr_next;
    logic [2:0]         line_pos_reg, line_pos_next;
    logic               data_match_reg, data_match_next;
    logic               name_match_reg, name_match_next;
    logic               cut_reg, cut_next;

    logic is_cr;
    logic is_lf;
    logic dm;
    logic nm;

    assign is_cr = (stream_byte == CHAR_CR);
    assign is_lf = (stream_byte == CHAR_LF);

    // prefix match including the current byte
    assign dm = data_match_reg &&
                ((line_pos_reg < DATA_TAG_LEN) ? (stream_byte == data_tag_char(line_pos_reg))
                                               : 1'b1);
    assign nm = name_match_reg &&
                ((line_pos_reg < NAME_TAG_LEN) ? (stream_byte == name_tag_char(line_pos_reg))
                                               : 1'b1);

    always_comb begin
        data_count_next = data_count_reg;
        name_count_next = name_count_reg;
        name_seen_next  = name_seen_reg;
        line_end_next   = line_end_reg;
        after_cr_next   = after_cr_reg;
        line_pos_next   = line_pos_reg;
        data_match_next = data_match_reg;
        name_match_next = name_match_reg;
        cut_next        = cut_reg;
        result          = '0;
        data_wr         = '0;
        name_wr         = '0;

        if (push_en) begin
            if (is_lf && after_cr_reg) begin
                // lf of a cr-lf pair
                after_cr_next = 1'b0;
            end else if (is_cr || is_lf) begin
                after_cr_next   = is_cr;
                line_pos_next   = '0;
                data_match_next = 1'b1;
                name_match_next = 1'b1;
                if (line_end_reg) begin
                    line_end_next = 1'b0;
                    if (data_count_reg != '0) begin
                        result.done         = 1'b1;
                        result.data_length  = DATA_LEN_W'(data_count_reg);
                        result.name_present = name_seen_reg;
                        result.name_length  = NAME_LEN_W'(name_count_reg);
                        result.truncated    = cut_reg;
                    end
                    data_count_next = '0;
                    name_count_next = '0;
                    name_seen_next  = 1'b0;
                    cut_next        = 1'b0;
                end else begin
                    line_end_next = 1'b1;
                end
            end else begin
                after_cr_next   = 1'b0;
                line_end_next   = 1'b0;
                data_match_next = dm;
                name_match_next = nm;

                if (line_pos_reg == DATA_TAG_LAST && dm) begin
                    data_count_next = '0;
                end else if (line_pos_reg > DATA_TAG_LAST && dm) begin
                    if (data_count_reg < DATA_CW'(DATA_DEPTH)) begin
                        data_wr.en      = 1'b1;
                        data_wr.addr    = data_count_reg[DATA_AW-1:0];
                        data_wr.data    = stream_byte;
                        data_count_next = data_count_reg + 1'b1;
                    end else begin
                        cut_next = 1'b1;
                    end
                end

                if (line_pos_reg == NAME_TAG_LAST && nm) begin
                    name_count_next = '0;
                    name_seen_next  = 1'b1;
                end else if (line_pos_reg > NAME_TAG_LAST && nm) begin
                    if (name_count_reg < NAME_CW'(NAME_DEPTH)) begin
                        name_wr.en      = 1'b1;
                        name_wr.addr    = name_count_reg[NAME_AW-1:0];
                        name_wr.data    = stream_byte;
                        name_count_next = name_count_reg + 1'b1;
                    end else begin
                        cut_next = 1'b1;
                    end
                end

                if (line_pos_reg != LINE_POS_MAX) begin
                    line_pos_next = line_pos_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_count_reg <= '0;
            name_count_reg <= '0;
            name_seen_reg  <= 1'b0;
            line_end_reg   <= 1'b0;
            after_cr_reg   <= 1'b0;
            line_pos_reg   <= '0;
            data_match_reg <= 1'b1;
            name_match_reg <= 1'b1;
            cut_reg        <= 1'b0;
        end else begin
            data_count_reg <= data_count_next;
            name_count_reg <= name_count_next;
            name_seen_reg  <= name_seen_next;
            line_end_reg   <= line_end_next;
            after_cr_reg   <= after_cr_next;
            line_pos_reg   <= line_pos_next;
            data_match_reg <= data_match_next;
            name_match_reg <= name_match_next;
            cut_reg        <= cut_next;
        end
    end

endmodule

// ===== rtl/core/sep_checker.sv =====
// ============================================================================
// sep_checker
// port-level checks of the event-stream parser, bound to the top level
// ============================================================================
module sep_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic                          m_event_done,
    input logic [sep_pkg::DATA_LEN_W-1:0] m_data_length,
    input logic                          m_name_present,
    input logic [sep_pkg::NAME_LEN_W-1:0] m_name_length,
    input logic                          m_truncated,
    input logic [sep_pkg::BYTE_W-1:0]     m_read_value
);
    import sep_pkg::*;

    // a stalled result word stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result word dropped while stalled");

    // reset empties the pipeline
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word valid right after reset");

    // event fields are zero unless an event completed
    a_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_event_done |->
            m_data_length == '0 && !m_name_present && m_name_length == '0 && !m_truncated)
        else $error("event fields set without a completed event");

    // a completed event always has data
    a_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_done |-> m_data_length != '0)
        else $error("completed event with empty data");

    // an event word never carries a read value
    a_noread: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_done |-> m_read_value == '0)
        else $error("read value on an event word");

endmodule

bind sse_event_stream_parser_top sep_checker u_sep_checker (.*);
